// ===== rtl/qmm_pkg.sv =====
// Shared constants, types and the square-root step for the quad motor mixer.
package qmm_pkg;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RP_GAIN    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAIN   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SCALE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT = CFG_IDX_W'(3);

  localparam logic [31:0] RP_GAIN_RST    = 32'd712348;
  localparam logic [31:0] YAW_GAIN_RST   = 32'd1687334;
  localparam logic [31:0] DUTY_SCALE_RST = 32'd65536;
  localparam logic [15:0] DUTY_LIMIT_RST = 16'd62259;

  localparam int unsigned TERM_W   = 44;  // torque term, Q.26 after floor shift
  localparam int unsigned MIX_W    = 46;  // mixed motor thrust, Q.26
  localparam int unsigned NUM_MOT  = 4;

  localparam int unsigned SQ_STAGES = 8;  // two root bits per stage
  localparam int unsigned REM_W     = 18;

  typedef logic signed [MIX_W-1:0] mix_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] rad;
  } rad_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [15:0]      root;
  } sq_t;

  // One digit of the restoring square root.
  function automatic sq_t sq_step(sq_t s, logic [1:0] d);
    logic [REM_W+1:0] acc;
    logic [REM_W+1:0] trial;
    sq_t              r;
    acc   = {s.rem, d};
    trial = {{(REM_W-16){1'b0}}, s.root, 2'b01};
    if (acc >= trial) begin
      r.rem  = REM_W'(acc - trial);
      r.root = {s.root[14:0], 1'b1};
    end else begin
      r.rem  = REM_W'(acc);
      r.root = {s.root[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== rtl/qmm_torque_mix.sv =====
// Torque scaling and X-frame mixing: two pipeline stages.
module qmm_torque_mix import qmm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [31:0] thrust_total_i,
  input  logic signed [31:0] torque_roll_i,
  input  logic signed [31:0] torque_pitch_i,
  input  logic signed [31:0] torque_yaw_i,
  input  logic        [31:0] rp_gain_i,
  input  logic        [31:0] yaw_gain_i,
  output logic               valid_o,
  output mix_t               mix_o [NUM_MOT]
);

  logic signed [32:0] rp_gain_s;
  logic signed [32:0] yaw_gain_s;
  logic signed [64:0] prod_r;
  logic signed [64:0] prod_p;
  logic signed [64:0] prod_y;

  logic                     v1_q;
  logic signed [31:0]       t_q;
  logic signed [TERM_W-1:0] r_q;
  logic signed [TERM_W-1:0] p_q;
  logic signed [TERM_W-1:0] y_q;

  logic signed [MIX_W-1:0]  t_e;
  logic signed [MIX_W-1:0]  r_e;
  logic signed [MIX_W-1:0]  p_e;
  logic signed [MIX_W-1:0]  y_e;

  logic v2_q;
  mix_t mix_q [NUM_MOT];

  assign rp_gain_s  = {1'b0, rp_gain_i};
  assign yaw_gain_s = {1'b0, yaw_gain_i};
  assign prod_r     = torque_roll_i * rp_gain_s;
  assign prod_p     = torque_pitch_i * rp_gain_s;
  assign prod_y     = torque_yaw_i * yaw_gain_s;

  // arithmetic shift by 20 floors to Q.26
  always_ff @(posedge clk_i) begin
    t_q <= thrust_total_i;
    r_q <= prod_r[63:20];
    p_q <= prod_p[63:20];
    y_q <= prod_y[63:20];
  end

  assign t_e = {{(MIX_W-32){t_q[31]}}, t_q};
  assign r_e = {{(MIX_W-TERM_W){r_q[TERM_W-1]}}, r_q};
  assign p_e = {{(MIX_W-TERM_W){p_q[TERM_W-1]}}, p_q};
  assign y_e = {{(MIX_W-TERM_W){y_q[TERM_W-1]}}, y_q};

  always_ff @(posedge clk_i) begin
    mix_q[0] <= t_e - r_e + p_e + y_e;
    mix_q[1] <= t_e - r_e - p_e - y_e;
    mix_q[2] <= t_e + r_e - p_e + y_e;
    mix_q[3] <= t_e + r_e + p_e - y_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign mix_o   = mix_q;

endmodule

// ===== rtl/qmm_ratio.sv =====
// Thrust clamp and thrust-times-scale ratio with saturation, three stages.
module qmm_ratio import qmm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  mix_t        mix_i,
  input  logic [31:0] scale_i,
  output logic        valid_o,
  output rad_t        rad_o
);

  logic        pos;
  logic [41:0] th;
  logic [52:0] lo_d;
  logic [52:0] hi_d;
  logic [73:0] full;
  rad_t        rad_d;

  logic        v3_q, v4_q, v5_q;
  logic [52:0] lo3_q, lo4_q, hi4_q;
  logic [20:0] thi3_q;
  logic        big3_q, big4_q;
  rad_t        rad_q;

  assign pos  = !mix_i[MIX_W-1];
  assign th   = pos ? mix_i[41:0] : 42'd0;
  assign lo_d = th[20:0] * scale_i;

  always_ff @(posedge clk_i) begin
    lo3_q  <= lo_d;
    thi3_q <= th[41:21];
    big3_q <= pos && (mix_i[MIX_W-2:42] != '0);
  end

  assign hi_d = thi3_q * scale_i;

  always_ff @(posedge clk_i) begin
    lo4_q  <= lo3_q;
    hi4_q  <= hi_d;
    big4_q <= big3_q;
  end

  assign full      = {hi4_q, 21'd0} + {21'd0, lo4_q};
  assign rad_d.sat = (big4_q && (scale_i != '0)) || (full[73:42] != '0);
  assign rad_d.rad = full[41:10];

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v3_q <= valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign valid_o = v5_q;
  assign rad_o   = rad_q;

endmodule

// ===== rtl/qmm_isqrt.sv =====
// Pipelined 32-bit integer square root, two root bits per stage.
module qmm_isqrt import qmm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  rad_t        rad_i,
  output logic        valid_o,
  output logic        sat_o,
  output logic [15:0] root_o
);

  logic        v_q   [SQ_STAGES];
  logic        sat_q [SQ_STAGES];
  logic [31:0] x_q   [SQ_STAGES];
  sq_t         s_q   [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stg
    logic        v_in;
    logic        sat_in;
    logic [31:0] x_in;
    sq_t         s_in;
    sq_t         s_mid;
    sq_t         s_out;

    if (g == 0) begin : g_first
      assign v_in   = valid_i;
      assign sat_in = rad_i.sat;
      assign x_in   = rad_i.rad;
      assign s_in   = '0;
    end else begin : g_next
      assign v_in   = v_q[g-1];
      assign sat_in = sat_q[g-1];
      assign x_in   = x_q[g-1];
      assign s_in   = s_q[g-1];
    end

    assign s_mid = sq_step(s_in, x_in[31:30]);
    assign s_out = sq_step(s_mid, x_in[29:28]);

    always_ff @(posedge clk_i) begin
      sat_q[g] <= sat_in;
      x_q[g]   <= {x_in[27:0], 4'd0};
      s_q[g]   <= s_out;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= v_in;
      end
    end
  end

  assign valid_o = v_q[SQ_STAGES-1];
  assign sat_o   = sat_q[SQ_STAGES-1];
  assign root_o  = s_q[SQ_STAGES-1].root;

endmodule

// ===== rtl/quad_motor_mixer_sqrt.sv =====
// Top level: config registers, mixer, ratio and root pipelines, duty clamp.
//
// A command transfers when start is high and busy is low; busy is always low,
// so one command may be taken every cycle. Its four duties appear on the duty
// ports for one cycle, marked by result_valid_o, and cannot be held off. They
// pass through the pipeline: torque multiply, mix, three ratio stages (the 42x32
// product is split into two 21x32 partial products), eight square-root stages of
// two bits each and the output register.
// Configuration writes take effect at once and belong to idle periods.
module quad_motor_mixer_sqrt import qmm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   thrust_total_i,
  input  logic signed [31:0]   torque_roll_i,
  input  logic signed [31:0]   torque_pitch_i,
  input  logic signed [31:0]   torque_yaw_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 result_valid_o,
  output logic [15:0]          duty_front_right_o,
  output logic [15:0]          duty_rear_right_o,
  output logic [15:0]          duty_rear_left_o,
  output logic [15:0]          duty_front_left_o
);

  logic [31:0] rp_gain_q;
  logic [31:0] yaw_gain_q;
  logic [31:0] duty_scale_q;
  logic [15:0] duty_limit_q;

  logic        mix_valid;
  mix_t        mix [NUM_MOT];
  logic        rad_valid [NUM_MOT];
  rad_t        rad [NUM_MOT];
  logic        sq_valid [NUM_MOT];
  logic        sq_sat [NUM_MOT];
  logic [15:0] sq_root [NUM_MOT];
  logic [15:0] duty_d [NUM_MOT];
  logic [15:0] duty_q [NUM_MOT];
  logic        out_valid_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_gain_q    <= RP_GAIN_RST;
      yaw_gain_q   <= YAW_GAIN_RST;
      duty_scale_q <= DUTY_SCALE_RST;
      duty_limit_q <= DUTY_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RP_GAIN:    rp_gain_q    <= cfg_data_i;
        CFG_YAW_GAIN:   yaw_gain_q   <= cfg_data_i;
        CFG_DUTY_SCALE: duty_scale_q <= cfg_data_i;
        CFG_DUTY_LIMIT: duty_limit_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  qmm_torque_mix u_mix (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (start && !busy),
    .thrust_total_i (thrust_total_i),
    .torque_roll_i  (torque_roll_i),
    .torque_pitch_i (torque_pitch_i),
    .torque_yaw_i   (torque_yaw_i),
    .rp_gain_i      (rp_gain_q),
    .yaw_gain_i     (yaw_gain_q),
    .valid_o        (mix_valid),
    .mix_o          (mix)
  );

  for (genvar m = 0; m < NUM_MOT; m++) begin : g_mot
    qmm_ratio u_ratio (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (mix_valid),
      .mix_i   (mix[m]),
      .scale_i (duty_scale_q),
      .valid_o (rad_valid[m]),
      .rad_o   (rad[m])
    );

    qmm_isqrt u_sqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (rad_valid[m]),
      .rad_i   (rad[m]),
      .valid_o (sq_valid[m]),
      .sat_o   (sq_sat[m]),
      .root_o  (sq_root[m])
    );

    // saturated ratio: raw duty of 1.0 clamps to full scale, then to the limit
    always_comb begin
      logic [15:0] raw;
      raw       = sq_sat[m] ? 16'hFFFF : sq_root[m];
      duty_d[m] = (raw > duty_limit_q) ? duty_limit_q : raw;
    end

    always_ff @(posedge clk_i) begin
      duty_q[m] <= duty_d[m];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= sq_valid[0];
    end
  end

  assign result_valid_o     = out_valid_q;
  assign duty_front_right_o = duty_q[0];
  assign duty_rear_right_o  = duty_q[1];
  assign duty_rear_left_o   = duty_q[2];
  assign duty_front_left_o  = duty_q[3];

endmodule

// ===== tb/qmm_duty_checker.sv =====
// Duty checker for the quad motor mixer: predicts the four duties per command and compares.
`timescale 1ns / 100ps
module qmm_duty_checker import qmm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic signed [31:0]   thrust_total_i,
  input  logic signed [31:0]   torque_roll_i,
  input  logic signed [31:0]   torque_pitch_i,
  input  logic signed [31:0]   torque_yaw_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 result_valid_i,
  input  logic [15:0]          duty_front_right_i,
  input  logic [15:0]          duty_rear_right_i,
  input  logic [15:0]          duty_rear_left_i,
  input  logic [15:0]          duty_front_left_i,
  output int                   mismatch_count_o,
  output int                   pending_o
);

  typedef logic [NUM_MOT-1:0][15:0] duty_set_t;

  localparam int unsigned TERM_SHIFT = 20;
  localparam int unsigned ROOT_DROP  = 5;
  localparam int unsigned ROOT_MSB   = 21;
  localparam logic [63:0] RATIO_ONE  = 64'd1 << 42;
  localparam logic [63:0] DUTY_MAX   = 64'hFFFF;

  logic [31:0] rp_gain;
  logic [31:0] yaw_gain;
  logic [31:0] duty_scale;
  logic [15:0] duty_limit;

  duty_set_t predicted_duties_q[$];
  int        mismatches = 0;
  int        pending = 0;
  string     motor_names[NUM_MOT] = '{"front_right", "rear_right", "rear_left", "front_left"};

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  task automatic note_mismatch(input string msg);
    $display("%0t ns: duty mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Q.30 torque times Q.16 gain, floored to Q.26
  function automatic longint torque_term(input logic signed [31:0] torque,
                                         input logic [31:0] gain);
    longint prod;
    prod = longint'(torque) * longint'({32'd0, gain});
    return prod >>> TERM_SHIFT;
  endfunction

  function automatic logic [15:0] thrust_to_duty(input longint thrust);
    logic [79:0] product;
    logic [63:0] ratio;
    logic [63:0] root;
    logic [63:0] trial;
    logic [63:0] duty;
    if (thrust <= 0 || duty_scale == '0) return '0;
    product = 80'(thrust) * 80'(duty_scale);
    ratio   = (product >= 80'(RATIO_ONE)) ? RATIO_ONE : product[63:0];
    root    = '0;
    for (int b = ROOT_MSB; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= ratio) root = trial;
    end
    duty = root >> ROOT_DROP;
    if (duty > DUTY_MAX) duty = DUTY_MAX;
    if (duty > 64'(duty_limit)) duty = 64'(duty_limit);
    return duty[15:0];
  endfunction

  function automatic duty_set_t predict_duties(input logic signed [31:0] thr,
                                               input logic signed [31:0] rol,
                                               input logic signed [31:0] pit,
                                               input logic signed [31:0] yw);
    longint    t;
    longint    r;
    longint    p;
    longint    y;
    duty_set_t d;
    t = longint'(thr);  // Q.24 / 4 read as Q.26
    r = torque_term(rol, rp_gain);
    p = torque_term(pit, rp_gain);
    y = torque_term(yw, yaw_gain);
    d[0] = thrust_to_duty(t - r + p + y);
    d[1] = thrust_to_duty(t - r - p - y);
    d[2] = thrust_to_duty(t + r - p + y);
    d[3] = thrust_to_duty(t + r + p - y);
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    duty_set_t got;
    duty_set_t want;
    if (!rst_ni) begin
      rp_gain    = RP_GAIN_RST;
      yaw_gain   = YAW_GAIN_RST;
      duty_scale = DUTY_SCALE_RST;
      duty_limit = DUTY_LIMIT_RST;
      predicted_duties_q.delete();
      pending = 0;
    end else begin
      if (result_valid_i) begin
        got = {duty_front_left_i, duty_rear_left_i, duty_rear_right_i, duty_front_right_i};
        if (predicted_duties_q.size() == 0) begin
          note_mismatch($sformatf("result %h with no command outstanding", got));
        end else begin
          want = predicted_duties_q.pop_front();
          for (int m = 0; m < NUM_MOT; m++) begin
            if (got[m] !== want[m]) begin
              note_mismatch($sformatf("%s duty %0d, predicted %0d",
                                      motor_names[m], got[m], want[m]));
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        predicted_duties_q.push_back(predict_duties(thrust_total_i, torque_roll_i,
                                                    torque_pitch_i, torque_yaw_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RP_GAIN:    rp_gain    = cfg_data_i;
          CFG_YAW_GAIN:   yaw_gain   = cfg_data_i;
          CFG_DUTY_SCALE: duty_scale = cfg_data_i;
          CFG_DUTY_LIMIT: duty_limit = cfg_data_i[15:0];
          default: ;
        endcase
      end
      pending = predicted_duties_q.size();
    end
  end

endmodule

// ===== tb/quad_motor_mixer_sqrt_test.sv =====
// Testbench top for the quad motor mixer: clock, reset, command and register stimulus, verdict.
`timescale 1ns / 100ps
module quad_motor_mixer_sqrt_test;
  import qmm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAST_LAST = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP       = '1;

  localparam logic [31:0] S_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN      = 32'h8000_0000;
  localparam logic [31:0] THRUST_ONE = 32'h0400_0000;  // ratio 1.0 at unit scale
  localparam logic [31:0] WORD_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] LIMIT_MAX  = 32'h0000_FFFF;

  localparam int unsigned PIPE_DEPTH       = 14;
  localparam int unsigned END_SLACK        = PIPE_DEPTH + 6;
  localparam int unsigned MAX_GAP          = 13;
  localparam int unsigned NUM_PHASES       = 9;
  localparam int unsigned RANDOM_PER_PHASE = 110;
  localparam int unsigned STRETCH_LEN      = 25;
  localparam int unsigned TIMEOUT_NS       = 2_000_000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic signed [31:0]   thrust_total_i;
  logic signed [31:0]   torque_roll_i;
  logic signed [31:0]   torque_pitch_i;
  logic signed [31:0]   torque_yaw_i;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]          cfg_data_i;
  logic                 result_valid_o;
  logic [15:0]          duty_front_right_o;
  logic [15:0]          duty_rear_right_o;
  logic [15:0]          duty_rear_left_o;
  logic [15:0]          duty_front_left_o;
  int                   mismatch_count;
  int                   pending;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  quad_motor_mixer_sqrt DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .thrust_total_i     (thrust_total_i),
    .torque_roll_i      (torque_roll_i),
    .torque_pitch_i     (torque_pitch_i),
    .torque_yaw_i       (torque_yaw_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .result_valid_o     (result_valid_o),
    .duty_front_right_o (duty_front_right_o),
    .duty_rear_right_o  (duty_rear_right_o),
    .duty_rear_left_o   (duty_rear_left_o),
    .duty_front_left_o  (duty_front_left_o)
  );

  qmm_duty_checker duty_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .thrust_total_i     (thrust_total_i),
    .torque_roll_i      (torque_roll_i),
    .torque_pitch_i     (torque_pitch_i),
    .torque_yaw_i       (torque_yaw_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .result_valid_i     (result_valid_o),
    .duty_front_right_i (duty_front_right_o),
    .duty_rear_right_i  (duty_rear_right_o),
    .duty_rear_left_i   (duty_rear_left_o),
    .duty_front_left_i  (duty_front_left_o),
    .mismatch_count_o   (mismatch_count),
    .pending_o          (pending)
  );

  // called just after a falling edge
  task automatic send_cmd(input logic [31:0] thr, input logic [31:0] rol,
                          input logic [31:0] pit, input logic [31:0] yw,
                          input int unsigned gap);
    start          = 1'b1;
    thrust_total_i = thr;
    torque_roll_i  = rol;
    torque_pitch_i = pit;
    torque_yaw_i   = yw;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    logic [31:0] mag;
    mag = $urandom >> $urandom_range(0, 31);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return mag;
      2: return -mag;
      default: return 32'($urandom_range(0, 64)) - 32'd32;
    endcase
  endfunction

  function automatic int unsigned rand_gap(input bit no_idle);
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic set_phase_config(input int unsigned ph);
    case (ph)
      1: begin
        cfg_write(CFG_RP_GAIN, WORD_MAX);
        cfg_write(CFG_YAW_GAIN, WORD_MAX);
        cfg_write(CFG_DUTY_SCALE, WORD_MAX);
        cfg_write(CFG_DUTY_LIMIT, LIMIT_MAX);
        // writes past the register map must be dropped
        cfg_write(CFG_IDX_PAST_LAST, '0);
        cfg_write(CFG_IDX_TOP, '0);
      end
      2: begin
        cfg_write(CFG_RP_GAIN, '0);
        cfg_write(CFG_YAW_GAIN, '0);
        cfg_write(CFG_DUTY_SCALE, '0);
        cfg_write(CFG_DUTY_LIMIT, '0);
      end
      3: begin
        cfg_write(CFG_YAW_GAIN, WORD_MAX);
        cfg_write(CFG_DUTY_SCALE, 32'd1);
        cfg_write(CFG_DUTY_LIMIT, LIMIT_MAX);
      end
      4: begin
        cfg_write(CFG_RP_GAIN, RP_GAIN_RST);
        cfg_write(CFG_YAW_GAIN, YAW_GAIN_RST);
        cfg_write(CFG_DUTY_SCALE, DUTY_SCALE_RST);
      end
      default: begin
        cfg_write(CFG_RP_GAIN, $urandom >> $urandom_range(0, 31));
        cfg_write(CFG_YAW_GAIN, $urandom >> $urandom_range(0, 31));
        cfg_write(CFG_DUTY_SCALE, $urandom >> $urandom_range(8, 31));
        cfg_write(CFG_DUTY_LIMIT, $urandom_range(0, 1) ? LIMIT_MAX : 32'($urandom_range(0, 65535)));
      end
    endcase
  endtask

  initial begin
    bit no_idle;
    rst_ni         = 1'b0;
    start          = 1'b0;
    thrust_total_i = '0;
    torque_roll_i  = '0;
    torque_pitch_i = '0;
    torque_yaw_i   = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset config: field extremes, each torque alone, clamp at zero and at full ratio
    send_cmd('0, '0, '0, '0, rand_gap(0));
    send_cmd(S_MAX, '0, '0, '0, rand_gap(0));
    send_cmd(S_MIN, '0, '0, '0, rand_gap(0));
    send_cmd(32'd1, '0, '0, '0, rand_gap(0));
    send_cmd(THRUST_ONE, '0, '0, '0, rand_gap(0));
    send_cmd(THRUST_ONE - 32'd1, '0, '0, '0, rand_gap(0));
    send_cmd(THRUST_ONE >> 2, '0, '0, '0, rand_gap(0));
    send_cmd(THRUST_ONE >> 2, 32'h0100_0000, '0, '0, rand_gap(0));
    send_cmd(THRUST_ONE >> 2, -32'h0100_0000, '0, '0, rand_gap(0));
    send_cmd(THRUST_ONE >> 2, '0, 32'h0100_0000, '0, rand_gap(0));
    send_cmd(THRUST_ONE >> 2, '0, -32'h0100_0000, '0, rand_gap(0));
    send_cmd(THRUST_ONE >> 2, '0, '0, 32'h0080_0000, rand_gap(0));
    send_cmd(THRUST_ONE >> 2, '0, '0, -32'h0080_0000, rand_gap(0));
    send_cmd('0, S_MAX, S_MAX, S_MAX, rand_gap(0));
    send_cmd('0, S_MIN, S_MIN, S_MIN, rand_gap(0));
    send_cmd(S_MAX, S_MAX, S_MAX, S_MAX, rand_gap(0));
    send_cmd(S_MIN, S_MIN, S_MIN, S_MIN, rand_gap(0));
    send_cmd(THRUST_ONE >> 2, WORD_MAX, WORD_MAX, WORD_MAX, rand_gap(0));
    send_cmd(WORD_MAX, 32'd1, 32'd1, 32'd1, rand_gap(0));
    send_cmd(S_MAX, S_MIN, S_MIN, S_MIN, rand_gap(1));

    no_idle = 1'b0;
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain_results();
        set_phase_config(ph);
      end
      for (int unsigned n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % STRETCH_LEN == 0) no_idle = ($urandom_range(0, 2) == 0);
        if (ph == 0 && n == RANDOM_PER_PHASE / 2) drain_results();
        send_cmd(rand_word(), rand_word(), rand_word(), rand_word(), rand_gap(no_idle));
      end
    end

    drain_results();
    repeat (END_SLACK) @(negedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
